### hw/rtl/rbmq_pkg.sv
// Shared types and constants for the ring buffer message queue.
// No dependencies; every other file of the block but rbmq_store imports this package.
package rbmq_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int SIZE_OFFSET  = 12;
  localparam int LEN_W        = 12;
  localparam int COUNT_W      = 13;
  localparam int COUNT_MAX    = 8191;
  localparam int SIZE_W       = 32;

  // Stream payload layout.
  localparam int S_DATA_W = 24;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 24;
  localparam int M_USER_W = 2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FLUSH  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HDR,
    S_CHECK,
    S_POP
  } state_t;

endpackage

### hw/rtl/rbmq_store.sv
// Byte store of the message queue: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module rbmq_store #(
  parameter int BUF_DEPTH = 4096,
  parameter int AW        = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/rbmq_admit.sv
// Overrun check, plus rejection of a zero length, for a new message against the read position.
// Depends on rbmq_pkg for the length width.
module rbmq_admit #(
  parameter int BUF_DEPTH = 4096,
  parameter int AW        = 12
) (
  input  logic [AW-1:0]             wr_index,
  input  logic [AW-1:0]             rd_index,
  input  logic [rbmq_pkg::LEN_W-1:0] len,
  output logic                      reject
);
  import rbmq_pkg::*;

  localparam int EW = ((AW > LEN_W) ? AW : LEN_W) + 1;

  logic [EW-1:0] p;
  logic [EW-1:0] r;
  logic [EW-1:0] msg_end;
  logic [EW-1:0] wrapped;
  logic [EW-1:0] depth;

  always_comb begin
    p       = EW'(wr_index);
    r       = EW'(rd_index);
    depth   = EW'(BUF_DEPTH);
    msg_end = p + EW'(len);
    wrapped = (msg_end >= depth) ? msg_end - depth : msg_end;
    reject  = (len == '0)
           || ((p < r) && (msg_end > r) && (msg_end < depth))
           || ((p < r) && (wrapped < r) && (msg_end > depth))
           || ((p > r) && (wrapped >= r) && (msg_end > depth));
  end

endmodule

### hw/rtl/ring_buffer_message_queue.sv
// Ring buffer message queue: byte-wide circular store of variable-length messages.
// Depends on rbmq_pkg, rbmq_admit and rbmq_store.
//
// Requests enter on the s_ channel and each produces exactly one result on the
// m_ channel. A write request carries one message byte; the first byte of a
// message also carries its total length and decides, by the overrun check
// against the read position, whether the whole message is stored or dropped.
// A read request pops one byte. At a message start the read fetches the
// 32-bit little-endian size from header offset 12 (with wrap) and adds the
// 16-byte header to get the message length. An oversize length clears the
// whole store and zeroes the message count.
//
// Sequencing: a write request has its result registered at the accepting edge.
// A read in the middle of a message goes from idle to the pop (one memory
// read). A read at a message start makes four header byte reads through the
// single read port, one size check, then the pop, or a flush if oversize.
// A read of an empty queue has its result registered at the accepting edge.
//
// Reset and flush: after reset, and after an oversize flush, a clearing pass
// writes zero to all BUF_DEPTH entries, one per cycle, so s_tready stays low
// until the pass is done. When the receiver stalls, the result waits in the
// output register and no new request is taken until it has left.
module ring_buffer_message_queue #(
  parameter int BUF_DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [7:0] wr_byte, [19:8] msg_length, [23:20] zero
  input  logic [rbmq_pkg::S_DATA_W-1:0] s_tdata,
  // [0] operation, [1] wr_first
  input  logic [rbmq_pkg::S_USER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] rd_byte, [20:8] msg_count, [23:21] zero
  output logic [rbmq_pkg::M_DATA_W-1:0] m_tdata,
  // [1:0] status
  output logic [rbmq_pkg::M_USER_W-1:0] m_tuser,
  output logic                          m_tlast
);
  import rbmq_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int RW = AW + 1;

  // Request fields.
  logic             op_read;
  logic [7:0]       wr_byte;
  logic             wr_first;
  logic [LEN_W-1:0] msg_length;

  assign op_read    = (s_tuser[0] == OP_READ);
  assign wr_first   = s_tuser[1];
  assign wr_byte    = s_tdata[7:0];
  assign msg_length = s_tdata[19:8];

  // Control state.
  state_t             state, state_next;
  logic [2:0]         hdr_cnt, hdr_cnt_next;
  logic [SIZE_W-1:0]  size_sh, size_sh_next;
  logic [AW-1:0]      clr_addr, clr_addr_next;
  logic [AW-1:0]      write_index, write_index_next;
  logic [AW-1:0]      read_index, read_index_next;
  logic [COUNT_W-1:0] held, held_next;
  logic [LEN_W-1:0]   wr_left, wr_left_next;
  logic               wr_ok, wr_ok_next;
  logic [RW-1:0]      rd_left, rd_left_next;

  // Output register.
  logic               out_valid, out_valid_next;
  status_t            out_status, out_status_next;
  logic [7:0]         out_byte, out_byte_next;
  logic               out_last, out_last_next;
  logic [COUNT_W-1:0] out_count, out_count_next;

  // Memory ports.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic          in_acc;
  logic          reject;
  logic          clearing;
  logic          oversize;
  logic          clr_done;
  logic [RW-1:0] hdr_sum;
  logic [AW-1:0] hdr_addr;

  assign in_acc   = s_tvalid && s_tready;
  assign clr_done = (clr_addr == AW'(BUF_DEPTH - 1));
  assign oversize = (size_sh > SIZE_W'(BUF_DEPTH - HEADER_BYTES));

  // Header byte address: read position plus size offset plus byte number, wrapped.
  always_comb begin
    hdr_sum  = RW'(read_index) + RW'(SIZE_OFFSET) + RW'(hdr_cnt[1:0]);
    hdr_addr = (hdr_sum >= RW'(BUF_DEPTH)) ? AW'(hdr_sum - RW'(BUF_DEPTH))
                                           : hdr_sum[AW-1:0];
  end

  rbmq_admit #(
    .BUF_DEPTH(BUF_DEPTH),
    .AW       (AW)
  ) u_admit (
    .wr_index(write_index),
    .rd_index(read_index),
    .len     (msg_length),
    .reject  (reject)
  );

  rbmq_store #(
    .BUF_DEPTH(BUF_DEPTH),
    .AW       (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc && op_read) begin
          if (rd_left != '0) begin
            state_next = S_POP;
          end else if (held != '0) begin
            state_next = S_HDR;
          end
        end
      end
      S_HDR: begin
        if (hdr_cnt == 3'd4) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = oversize ? S_CLEAR : S_POP;
      end
      S_POP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State machine outputs: handshake, clearing pass and read address.
  always_comb begin
    s_tready  = 1'b0;
    clearing  = 1'b0;
    mem_raddr = read_index;
    unique case (state)
      S_CLEAR: clearing = 1'b1;
      S_IDLE:  s_tready = !out_valid || m_tready;
      S_HDR:   mem_raddr = hdr_addr;
      S_CHECK: mem_raddr = read_index;
      S_POP:   mem_raddr = read_index;
      default: s_tready = 1'b0;
    endcase
  end

  // Datapath: queue bookkeeping, memory writes and the result register.
  always_comb begin
    logic [LEN_W-1:0] left_eff;
    logic             ok_eff;
    logic [LEN_W-1:0] left_dec;
    logic [RW-1:0]    rd_dec;

    hdr_cnt_next     = '0;
    size_sh_next     = size_sh;
    clr_addr_next    = clr_addr;
    write_index_next = write_index;
    read_index_next  = read_index;
    held_next        = held;
    wr_left_next     = wr_left;
    wr_ok_next       = wr_ok;
    rd_left_next     = rd_left;
    out_valid_next   = m_tready ? 1'b0 : out_valid;
    out_status_next  = out_status;
    out_byte_next    = out_byte;
    out_last_next    = out_last;
    out_count_next   = out_count;
    mem_we           = 1'b0;
    mem_waddr        = write_index;
    mem_wdata        = wr_byte;

    left_eff = wr_first ? msg_length : wr_left;
    ok_eff   = wr_first ? !reject : wr_ok;
    left_dec = left_eff - 1'b1;
    rd_dec   = rd_left - 1'b1;

    if (clearing) begin
      mem_we        = 1'b1;
      mem_waddr     = clr_addr;
      mem_wdata     = '0;
      clr_addr_next = clr_done ? '0 : clr_addr + 1'b1;
    end

    if (in_acc && !op_read) begin
      // Write request: result is settled in this cycle.
      out_valid_next  = 1'b1;
      out_byte_next   = '0;
      out_last_next   = 1'b0;
      out_status_next = ST_REJECT;
      wr_ok_next      = ok_eff;
      wr_left_next    = left_eff;
      if (left_eff != '0) begin
        wr_left_next = left_dec;
        if (ok_eff) begin
          out_status_next  = ST_OK;
          mem_we           = 1'b1;
          write_index_next = (write_index == AW'(BUF_DEPTH - 1)) ? '0
                                                                 : write_index + 1'b1;
          if ((left_dec == '0) && (held != COUNT_W'(COUNT_MAX))) begin
            held_next = held + 1'b1;
          end
        end
      end
      out_count_next = held_next;
    end

    if (in_acc && op_read && (rd_left == '0) && (held == '0)) begin
      out_valid_next  = 1'b1;
      out_status_next = ST_EMPTY;
      out_byte_next   = '0;
      out_last_next   = 1'b0;
      out_count_next  = held;
    end

    if (state == S_HDR) begin
      hdr_cnt_next = hdr_cnt + 1'b1;
      if (hdr_cnt != '0) begin
        // Bytes arrive lowest first, so shifting in from the top builds the word.
        size_sh_next = {mem_rdata, size_sh[SIZE_W-1:8]};
      end
    end

    if (state == S_CHECK) begin
      if (oversize) begin
        held_next       = '0;
        out_valid_next  = 1'b1;
        out_status_next = ST_FLUSH;
        out_byte_next   = '0;
        out_last_next   = 1'b0;
        out_count_next  = '0;
      end else begin
        rd_left_next = RW'(HEADER_BYTES) + size_sh[RW-1:0];
        held_next    = held - 1'b1;
      end
    end

    if (state == S_POP) begin
      rd_left_next    = rd_dec;
      read_index_next = (read_index == AW'(BUF_DEPTH - 1)) ? '0 : read_index + 1'b1;
      out_valid_next  = 1'b1;
      out_status_next = ST_OK;
      out_byte_next   = mem_rdata;
      out_last_next   = (rd_dec == '0);
      out_count_next  = held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      hdr_cnt     <= '0;
      clr_addr    <= '0;
      write_index <= '0;
      read_index  <= '0;
      held        <= '0;
      wr_left     <= '0;
      wr_ok       <= 1'b0;
      rd_left     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      hdr_cnt     <= hdr_cnt_next;
      clr_addr    <= clr_addr_next;
      write_index <= write_index_next;
      read_index  <= read_index_next;
      held        <= held_next;
      wr_left     <= wr_left_next;
      wr_ok       <= wr_ok_next;
      rd_left     <= rd_left_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    size_sh    <= size_sh_next;
    out_status <= out_status_next;
    out_byte   <= out_byte_next;
    out_last   <= out_last_next;
    out_count  <= out_count_next;
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {(M_DATA_W - COUNT_W - 8)'(0), out_count, out_byte};

endmodule

### hw/rtl/rbmq_checker.sv
// Port-level checks for the ring buffer message queue, bound to the top level.
// Depends on rbmq_pkg and ring_buffer_message_queue.
module rbmq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rbmq_pkg::M_DATA_W-1:0] m_tdata,
  input logic [rbmq_pkg::M_USER_W-1:0] m_tuser,
  input logic                          m_tlast
);
  import rbmq_pkg::*;

  // The clearing pass after reset keeps the input closed.
  a_reset_clears : assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request taken right after reset");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_last_ok : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == ST_OK)
    else $error("last flag on a result that popped nothing");

  a_flush_empty : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FLUSH || m_tuser == ST_EMPTY) |-> m_tdata[20:8] == '0)
    else $error("message count not zero after flush or empty read");

  a_no_byte : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[7:0] == '0)
    else $error("byte on a result that popped nothing");

endmodule

bind ring_buffer_message_queue rbmq_checker u_rbmq_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

### dv/testbench.sv
// Self-checking testbench for the ring buffer message queue.
// Depends on rbmq_pkg and ring_buffer_message_queue; holds its own queue predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rbmq_pkg::*;

  localparam int DEPTH          = 4096;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int FLUSH_BUDGET   = 60;
  localparam int LONG_STALL     = 120;
  localparam int SHORT_MESSAGES = 40;

  typedef struct packed {
    status_t     status;
    logic [7:0]  rd_byte;
    logic        rd_last;
    logic [12:0] msg_count;
  } reply_t;

  typedef struct {
    logic [7:0]  data;
    bit          first;
    logic [11:0] len;
  } wr_item_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [S_USER_W-1:0] s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;
  logic                m_tlast;

  // Shadow copy of the queue state, advanced once per accepted request.
  logic [7:0]  shadow_mem [DEPTH];
  int unsigned shadow_wr, shadow_rd, shadow_held;
  int unsigned shadow_wr_left, shadow_rd_left;
  bit          shadow_wr_ok;

  reply_t   replies_due [$];
  wr_item_t msg_bytes [$];

  int unsigned error_count, requests_sent, replies_checked;
  int unsigned flush_count, reject_count, empty_count;
  bit          allow_idle = 1'b1;
  bit          long_stall_req = 1'b0;

  ring_buffer_message_queue #(.BUF_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Overrun rule applied by the first byte of a message against the read position.
  function automatic bit would_overrun(int unsigned p, int unsigned r, int unsigned len);
    int unsigned stop_pos, wrapped;
    stop_pos = p + len;
    wrapped  = (stop_pos >= DEPTH) ? stop_pos - DEPTH : stop_pos;
    if (p < r && stop_pos > r && stop_pos < DEPTH) return 1'b1;
    if (p < r && wrapped < r && stop_pos > DEPTH) return 1'b1;
    if (p > r && wrapped >= r && stop_pos > DEPTH) return 1'b1;
    return 1'b0;
  endfunction

  // Header length plus the little-endian size word found at offset 12, read with wrap.
  function automatic longint unsigned header_total(int unsigned rd_pos);
    logic [31:0] size_word;
    for (int k = 3; k >= 0; k--)
      size_word = {size_word[23:0], shadow_mem[12'((rd_pos + SIZE_OFFSET + k) % DEPTH)]};
    return longint'(HEADER_BYTES) + longint'(size_word);
  endfunction

  function automatic bit flush_ahead();
    return shadow_rd_left == 0 && shadow_held != 0 && header_total(shadow_rd) > DEPTH;
  endfunction

  function automatic void predict_reply(op_t op, logic [7:0] data, bit first,
                                        logic [11:0] len);
    reply_t      reply;
    bit          pop;
    longint unsigned total;
    reply = '{status: ST_OK, rd_byte: 8'h00, rd_last: 1'b0, msg_count: '0};
    if (op == OP_WRITE) begin
      if (first) begin
        shadow_wr_left = 32'(len);
        shadow_wr_ok   = (len != 0) && !would_overrun(shadow_wr, shadow_rd, 32'(len));
      end
      if (shadow_wr_left == 0) begin
        reply.status = ST_REJECT;
      end else if (!shadow_wr_ok) begin
        shadow_wr_left--;
        reply.status = ST_REJECT;
      end else begin
        shadow_mem[12'(shadow_wr)] = data;
        shadow_wr = (shadow_wr + 1) % DEPTH;
        shadow_wr_left--;
        if (shadow_wr_left == 0 && shadow_held < COUNT_MAX) shadow_held++;
      end
    end else begin
      pop = 1'b1;
      if (shadow_rd_left == 0) begin
        if (shadow_held == 0) begin
          reply.status = ST_EMPTY;
          pop = 1'b0;
        end else begin
          total = header_total(shadow_rd);
          if (total > DEPTH) begin
            // Oversize length: the whole store is wiped, positions stay where they are.
            foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
            shadow_held  = 0;
            reply.status = ST_FLUSH;
            pop = 1'b0;
          end else begin
            shadow_rd_left = int'(total);
            shadow_held--;
          end
        end
      end
      if (pop) begin
        reply.rd_byte = shadow_mem[12'(shadow_rd)];
        shadow_rd = (shadow_rd + 1) % DEPTH;
        shadow_rd_left--;
        reply.rd_last = (shadow_rd_left == 0);
      end
    end
    reply.msg_count = shadow_held[12:0];
    case (reply.status)
      ST_REJECT: reject_count++;
      ST_EMPTY:  empty_count++;
      ST_FLUSH:  flush_count++;
      default:   ;
    endcase
    replies_due.push_back(reply);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offers one request and returns at the edge that accepts it, or after an idle gap.
  // Unless that gap was taken, tvalid stays high on return, so the caller either sends
  // again at once or calls finish_burst.
  task automatic send_request(op_t op, logic [7:0] data, bit first, logic [11:0] len);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, len, data};
    s_tuser  <= {first, op};
    do @(posedge clk); while (!s_tready);
    predict_reply(op, data, first, len);
    requests_sent++;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Read fields other than the operation are don't-care, so they get random bits.
  task automatic send_read();
    send_request(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 12'($urandom_range(0, 4095)));
  endtask

  task automatic finish_burst();
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Queues the first `sent` bytes of a message of `total` bytes whose header
  // carries `size_word` at offset 12.
  function automatic void plan_message(int total, logic [31:0] size_word, int sent);
    wr_item_t item;
    for (int k = 0; k < sent; k++) begin
      item.first = (k == 0);
      item.len   = (k == 0) ? total[11:0] : 12'($urandom_range(0, 4095));
      if (k >= SIZE_OFFSET && k < HEADER_BYTES)
        item.data = size_word[8*(k-SIZE_OFFSET) +: 8];
      else if (k < SIZE_OFFSET)
        item.data = 8'($urandom_range(0, 255));
      else
        // Many zero payload bytes keep misaligned header reads from flushing too often.
        item.data = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
      msg_bytes.push_back(item);
    end
  endfunction

  function automatic void plan_random_message();
    int       kind, total, size;
    wr_item_t item;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      size  = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 200) : $urandom_range(0, 48);
      total = HEADER_BYTES + size;
      plan_message(total, size, total);
    end else if (kind < 78) begin
      // Size word disagrees with the written length, so the reader drifts.
      total = HEADER_BYTES + $urandom_range(0, 48);
      plan_message(total, $urandom_range(0, 64), total);
    end else if (kind < 82) begin
      total = HEADER_BYTES + $urandom_range(0, 16);
      plan_message(total, $urandom | 32'h0000_1000, total);
    end else if (kind < 88) begin
      total = $urandom_range(1, HEADER_BYTES - 1);
      plan_message(total, 0, total);
    end else if (kind < 93) begin
      // Truncated message, abandoned by whatever first byte comes next.
      size  = $urandom_range(0, 48);
      total = HEADER_BYTES + size;
      plan_message(total, size, $urandom_range(1, total - 1));
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          item.first = 1'b0;
          item.data  = 8'($urandom_range(0, 255));
          item.len   = 12'($urandom_range(0, 4095));
          msg_bytes.push_back(item);
        end
        1: plan_message(0, 0, $urandom_range(1, 3));
        default: plan_message($urandom_range(16, 4095), $urandom, $urandom_range(1, 4));
      endcase
    end
  endfunction

  task automatic send_planned();
    wr_item_t item;
    while (msg_bytes.size() != 0) begin
      item = msg_bytes.pop_front();
      send_request(OP_WRITE, item.data, item.first, item.len);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: random stalls, plus one long hold-off whenever the request bit toggles.
  initial begin
    int unsigned stall_left, burst_left;
    bit          stall_ack;
    stall_left = 0;
    burst_left = 0;
    stall_ack  = 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req != stall_ack) begin
        stall_ack  = long_stall_req;
        stall_left = LONG_STALL;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (burst_left != 0) begin
        burst_left--;
        m_tready <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 5);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      replies_checked++;
      if (replies_due.size() == 0) begin
        $error("reply with none expected: status %0d, data %0h", m_tuser, m_tdata);
        error_count++;
      end else begin
        want = replies_due.pop_front();
        if (m_tuser !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
          error_count++;
        end
        if (m_tdata[7:0] !== want.rd_byte) begin
          $error("rd_byte mismatch: expected %0h, actual %0h", want.rd_byte, m_tdata[7:0]);
          error_count++;
        end
        if (m_tlast !== want.rd_last) begin
          $error("rd_last mismatch: expected %0d, actual %0d", want.rd_last, m_tlast);
          error_count++;
        end
        if (m_tdata[20:8] !== want.msg_count) begin
          $error("msg_count mismatch: expected %0d, actual %0d",
                 want.msg_count, m_tdata[20:8]);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty read, a stray byte, a zero-length first byte and a stray byte after it.
  task automatic test_empty_and_stray();
    send_read();
    send_request(OP_WRITE, 8'hA5, 1'b0, 12'd7);
    send_request(OP_WRITE, 8'hFF, 1'b1, 12'd0);
    send_request(OP_WRITE, 8'h00, 1'b0, 12'hFFF);
    finish_burst();
  endtask

  // One well-formed header-only message stored and read back, then an empty read.
  task automatic test_message_roundtrip();
    plan_message(HEADER_BYTES, 0, HEADER_BYTES);
    msg_bytes[0].data = 8'hFF;
    msg_bytes[1].data = 8'h00;
    send_planned();
    send_read();
    while (shadow_rd_left != 0) send_read();
    send_read();
    finish_burst();
  endtask

  // Lengths picked from the current positions to hit each overrun rule and the
  // exact-fit boundary that must pass.
  task automatic test_overrun_checks();
    // Write ahead of the reader, then a length that wraps onto the read position.
    if (shadow_wr == shadow_rd) send_request(OP_WRITE, 8'h3C, 1'b1, 12'd1);
    if (shadow_wr > shadow_rd) begin
      send_request(OP_WRITE, 8'hC3, 1'b1, 12'd4095);
      send_request(OP_WRITE, 8'h5A, 1'b0, 12'd0);
    end
    // Pop one message so that the reader runs past the writer.
    send_read();
    while (shadow_rd_left != 0) send_read();
    if (shadow_wr < shadow_rd) begin
      send_request(OP_WRITE, 8'h11, 1'b1, 12'(shadow_rd - shadow_wr + 1));
      send_request(OP_WRITE, 8'h22, 1'b1, 12'd4095);
      // Ends exactly at the read position: accepted.
      plan_message(shadow_rd - shadow_wr, 0, shadow_rd - shadow_wr);
      send_planned();
    end
    finish_burst();
  endtask

  // The receiver holds off while a full message is offered back to back.
  task automatic test_backpressure();
    allow_idle = 1'b0;
    long_stall_req <= ~long_stall_req;
    plan_message(HEADER_BYTES + 8, 8, HEADER_BYTES + 8);
    send_planned();
    finish_burst();
    allow_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned read_pct;
    bit          do_read;
    wr_item_t    item;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      allow_idle = (i < RANDOM_ITEMS - 200) && ((i / 150) % 3 != 2);
      read_pct = (shadow_held >= 4 || shadow_rd_left != 0) ? 60 : 35;
      do_read  = $urandom_range(0, 99) < read_pct;
      // Each flush costs a full clearing pass, so their number is capped.
      if (do_read && flush_count >= FLUSH_BUDGET && flush_ahead()) do_read = 1'b0;
      if (do_read) begin
        send_read();
      end else begin
        if (msg_bytes.size() == 0) plan_random_message();
        item = msg_bytes.pop_front();
        send_request(OP_WRITE, item.data, item.first, item.len);
      end
    end
    msg_bytes.delete();
    finish_burst();
  endtask

  // Single-byte messages always pass the overrun rule and each raises the count;
  // the reads after them start at whatever header the store holds.
  task automatic test_short_messages();
    allow_idle = 1'b0;
    while (shadow_rd_left != 0) send_read();
    for (int i = 0; i < SHORT_MESSAGES; i++) send_request(OP_WRITE, 8'hFF, 1'b1, 12'd1);
    send_read();
    send_read();
    finish_burst();
  endtask

  initial begin
    foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
    shadow_wr      = 0;
    shadow_rd      = 0;
    shadow_held    = 0;
    shadow_wr_left = 0;
    shadow_rd_left = 0;
    shadow_wr_ok   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_stray();
    test_message_roundtrip();
    test_overrun_checks();
    test_backpressure();
    test_random_traffic();
    test_short_messages();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests and %0d replies, with %0d rejected writes,",
             requests_sent, replies_checked, reject_count);
    $display("%0d empty reads and %0d oversize flushes.", empty_count, flush_count);
    if (error_count == 0 && replies_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
